FILE: src/output_mask_with_change_log_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the output mask with change log
// Shared property wrappers, clocked on clk, held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef OUTPUT_MASK_WITH_CHANGE_LOG_ASSERT_SVH
`define OUTPUT_MASK_WITH_CHANGE_LOG_ASSERT_SVH

// general property, may use |-> or |=>
`define OMCL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition that must never be seen
`define OMCL_ASSERT_NEVER(lbl, expr, msg) \
	`OMCL_ASSERT(lbl, !(expr), msg)

`endif

FILE: src/omcl_pkg.sv
// ----------------------------------------------------------------------------
// omcl_pkg
// Constants, command codes and shared types of the output mask with change log.
// ----------------------------------------------------------------------------
package omcl_pkg;

	localparam int CHANNELS      = 10;
	// ring slot is taken from the low bits of the event count: keep a power of two
	localparam int HISTORY_DEPTH = 16;
	localparam int MAX_RESULTS   = 16;

	localparam int MASK_W   = 10;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int HIST_AW  = $clog2(HISTORY_DEPTH);
	localparam int ENTRY_W  = 32 + CHANNELS;

	typedef logic [2:0]          cmd_t;
	typedef logic [CHANNELS-1:0] chmask_t;

	localparam cmd_t CMD_SET   = 3'd0;
	localparam cmd_t CMD_CLEAR = 3'd1;
	localparam cmd_t CMD_LOAD  = 3'd2;
	localparam cmd_t CMD_QUERY = 3'd3;
	localparam cmd_t CMD_READ  = 3'd4;

	typedef struct packed {
		chmask_t     mask;
		logic        changed;
		logic        chan_on;
		logic [31:0] on_ms;
	} mask_res_t;

endpackage

FILE: src/omcl_ram.sv
// ----------------------------------------------------------------------------
// omcl_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module omcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/omcl_mask.sv
// ----------------------------------------------------------------------------
// omcl_mask
// Enable mask and per-channel last-on times; works out the next mask of a word.
// ----------------------------------------------------------------------------
module omcl_mask (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  omcl_pkg::cmd_t      cmd,
	input  logic [3:0]          chan_idx,
	input  logic                turn_on,
	input  logic [15:0]         new_mask,
	input  logic                running,
	input  logic [31:0]         now_ms,
	output omcl_pkg::mask_res_t res
);
	import omcl_pkg::*;

	chmask_t               mask_q;
	logic [31:0]           last_on_q [CHANNELS];
	logic                  idx_ok;
	logic [CH_IDX_W-1:0]   sel;
	chmask_t               bit_m;
	chmask_t               target;
	chmask_t               rise;
	logic                  is_query;

	always_comb begin
		idx_ok   = (chan_idx != 4'd0) && (5'(chan_idx) <= 5'(CHANNELS));
		sel      = CH_IDX_W'(chan_idx - 4'd1);
		bit_m    = chmask_t'(1) << sel;
		is_query = (cmd == CMD_QUERY) && idx_ok;
		unique case (cmd)
			CMD_SET: begin
				if (!idx_ok) begin
					target = mask_q;
				end else if (turn_on) begin
					target = mask_q | bit_m;
				end else begin
					target = mask_q & ~bit_m;
				end
			end
			CMD_CLEAR: target = '0;
			CMD_LOAD:  target = running ? CHANNELS'(new_mask) : '0;
			default:   target = mask_q;
		endcase
		rise        = target & ~mask_q;
		res.mask    = target;
		res.changed = (target != mask_q);
		res.chan_on = is_query && mask_q[sel];
		res.on_ms   = is_query ? last_on_q[sel] : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				last_on_q[i] <= 32'd0;
			end
		end else if (commit) begin
			mask_q <= target;
			// off to on stamps the channel
			for (int i = 0; i < CHANNELS; i++) begin
				if (rise[i]) begin
					last_on_q[i] <= now_ms;
				end
			end
		end
	end

endmodule

FILE: src/output_mask_with_change_log.sv
// ----------------------------------------------------------------------------
// output_mask_with_change_log
// Channel enable mask with last-on times and a ring of mask change events.
// ----------------------------------------------------------------------------
//  channel  dir  tdata / tuser / tlast
//  s_*      in   command in tuser; index, on, mask, running, time, seq, max
//  m_*      out  mask and query fields, entry fields; entry_valid in tuser
//
//  A control or query word is captured, then commits and loads its result once
//  the output is free. A history read is captured and set up, then each entry
//  takes a ring RAM read state and a data state for the registered read data.
//  Reset clears the mask, last-on times and event count; ring entries are
//  only read once written. A stalled output holds the next word in its stage.
// ----------------------------------------------------------------------------
module output_mask_with_change_log (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// channel_index, turn_on, new_mask, device_running, now_ms, from_seq, max_entries
	input  logic [95:0]  s_tdata,
	// command
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// mask_now, mask_changed, channel_on, channel_last_on_ms, entry_time_ms,
	// entry_mask, next_seq
	output logic [119:0] m_tdata,
	// entry_valid
	output logic         m_tuser,
	output logic         m_tlast
);
	import omcl_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_AVAIL = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_DATA  = 3'd4;

	logic [2:0]         state_q;
	cmd_t               cmd_q;
	logic [3:0]         idx_q;
	logic               on_q;
	logic [15:0]        nm_q;
	logic               run_q;
	logic [31:0]        now_q;
	logic [31:0]        from_q;
	logic [4:0]         maxe_q;

	logic [31:0]        count_q;
	logic [31:0]        from_c_q;
	logic [31:0]        nseq_q;
	logic [4:0]         rem_q;
	logic [HIST_AW-1:0] ptr_q;

	logic               m_valid_q;
	logic [MASK_W-1:0]  od_mask_q;
	logic               od_chg_q;
	logic               od_on_q;
	logic [31:0]        od_onms_q;
	logic               od_ev_q;
	logic [31:0]        od_etime_q;
	logic [MASK_W-1:0]  od_emask_q;
	logic [31:0]        od_nseq_q;
	logic               od_last_q;

	mask_res_t          mres;
	logic               out_free;
	logic               commit;
	logic               ram_we;
	logic               ram_re;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [31:0]        lo;
	logic [31:0]        from_c;
	logic [31:0]        diff;
	logic [4:0]         maxc;
	logic [4:0]         avail;
	logic               single;
	logic [31:0]        single_seq;
	logic               out_load;

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_valid_q || m_tready;

	omcl_mask u_mask (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (commit),
		.cmd      (cmd_q),
		.chan_idx (idx_q),
		.turn_on  (on_q),
		.new_mask (nm_q),
		.running  (run_q),
		.now_ms   (now_q),
		.res      (mres)
	);

	// ring of {time, mask}; slot is the low bits of the event count
	omcl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (HISTORY_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[HIST_AW-1:0]),
		.wdata ({now_q, mres.mask}),
		.re    (ram_re),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		commit = (state_q == ST_EXEC) && out_free && (cmd_q != CMD_READ);
		// the newest logged mask always equals the current one, so any change logs
		ram_we = commit && mres.changed;
		ram_re = (state_q == ST_RD);

		lo     = (count_q > 32'(HISTORY_DEPTH)) ? count_q - 32'(HISTORY_DEPTH) : 32'd0;
		if (from_q < lo) begin
			from_c = lo;
		end else if (from_q > count_q) begin
			from_c = count_q;
		end else begin
			from_c = from_q;
		end

		diff  = count_q - from_c_q;
		maxc  = (maxe_q > 5'(MAX_RESULTS)) ? 5'(MAX_RESULTS) : maxe_q;
		avail = (diff < 32'(maxc)) ? diff[4:0] : maxc;

		single = (maxe_q == 5'd0) || (count_q == 32'd0) || (avail == 5'd0);
		priority if (maxe_q == 5'd0) begin
			single_seq = from_q;
		end else if (count_q == 32'd0) begin
			single_seq = 32'd0;
		end else begin
			single_seq = from_c_q;
		end

		out_load = out_free && (commit || ((state_q == ST_AVAIL) && single) ||
			(state_q == ST_DATA));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= 32'd0;
		end else begin
			if (ram_we) begin
				count_q <= count_q + 32'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd_q == CMD_READ) begin
						state_q <= ST_AVAIL;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_AVAIL: begin
					if (!single) begin
						state_q <= ST_RD;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD: state_q <= ST_DATA;
				ST_DATA: begin
					if (out_free) begin
						state_q <= (rem_q == 5'd0) ? ST_IDLE : ST_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// input capture and read sequencer registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q  <= s_tuser;
			idx_q  <= s_tdata[3:0];
			on_q   <= s_tdata[4];
			nm_q   <= s_tdata[20:5];
			run_q  <= s_tdata[21];
			now_q  <= s_tdata[53:22];
			from_q <= s_tdata[85:54];
			maxe_q <= s_tdata[90:86];
		end
		if (state_q == ST_EXEC) begin
			from_c_q <= from_c;
		end
		if ((state_q == ST_AVAIL) && !single) begin
			rem_q  <= avail;
			ptr_q  <= from_c_q[HIST_AW-1:0];
			nseq_q <= from_c_q + 32'(avail);
		end
		if (state_q == ST_RD) begin
			rem_q <= rem_q - 5'd1;
			ptr_q <= ptr_q + HIST_AW'(1);
		end
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			od_mask_q <= MASK_W'(mres.mask);
			od_chg_q  <= commit && mres.changed;
			od_on_q   <= commit && mres.chan_on;
			od_onms_q <= commit ? mres.on_ms : 32'd0;
			if (state_q == ST_DATA) begin
				od_ev_q    <= 1'b1;
				od_etime_q <= ram_rdata[ENTRY_W-1:CHANNELS];
				od_emask_q <= MASK_W'(ram_rdata[CHANNELS-1:0]);
				od_nseq_q  <= nseq_q;
				od_last_q  <= (rem_q == 5'd0);
			end else begin
				od_ev_q    <= 1'b0;
				od_etime_q <= 32'd0;
				od_emask_q <= '0;
				od_nseq_q  <= (state_q == ST_AVAIL) ? single_seq : 32'd0;
				od_last_q  <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = od_ev_q;
	assign m_tlast  = od_last_q;
	assign m_tdata  = {2'b00, od_nseq_q, od_emask_q, od_etime_q, od_onms_q, od_on_q,
		od_chg_q, od_mask_q};

`include "output_mask_with_change_log_assert.svh"

	`OMCL_ASSERT_NEVER(a_rd_empty, (state_q == ST_RD) && (rem_q == 5'd0), "read with no entries left")
	`OMCL_ASSERT(a_log_count, ram_we |=> (count_q == $past(count_q) + 32'd1), "event count not advanced")
	`OMCL_ASSERT(a_entry_nochg, (m_valid_q && od_ev_q) |-> !od_chg_q, "entry word marks a change")
	`OMCL_ASSERT(a_load_free, out_load |-> out_free, "output stage overwritten")

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Output mask with change log: self-checking testbench
// Drives command words through the slave stream and checks every result word
// against a predictor that keeps its own copy of the mask, last-on times and
// event ring. A directed opening is followed by about 200 random commands,
// with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import omcl_pkg::*;

	localparam cmd_t CMD_SPARE_LO = 3'd5;
	localparam cmd_t CMD_SPARE_HI = 3'd7;
	localparam int   RANDOM_CMDS  = 200;
	localparam int   CYCLE_LIMIT  = 300000;

	typedef struct {
		cmd_t        cmd;
		logic [3:0]  idx;
		logic        on;
		logic [15:0] nm;
		logic        run;
		logic [31:0] now;
		logic [31:0] from;
		logic [4:0]  maxe;
		bit          drain;	// hold this word back until all results are in
	} cmd_item_t;

	typedef struct {
		chmask_t     mask_now;
		logic        changed;
		logic        chan_on;
		logic [31:0] on_ms;
		logic        entry_valid;
		logic [31:0] entry_time;
		chmask_t     entry_mask;
		logic [31:0] next_seq;
		logic        is_last;
	} log_word_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [95:0]  s_tdata = '0;	// channel_index, turn_on, new_mask, device_running,
					// now_ms, from_seq, max_entries
	logic [2:0]   s_tuser = CMD_SET;	// command
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [119:0] m_tdata;	// mask_now, mask_changed, channel_on, channel_last_on_ms,
					// entry_time_ms, entry_mask, next_seq
	logic         m_tuser;	// entry_valid
	logic         m_tlast;

	output_mask_with_change_log u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted block state
	chmask_t     mask_q;
	logic [31:0] on_time_q  [CHANNELS];
	logic [31:0] ring_time  [HISTORY_DEPTH];
	chmask_t     ring_mask  [HISTORY_DEPTH];
	logic [31:0] event_total;

	cmd_item_t pending_cmds [$];
	log_word_t expected_words [$];
	int        errors = 0;
	int        cycles = 0;

	task automatic log_event(input chmask_t m, input logic [31:0] t);
		logic [31:0] prev;
		prev = event_total - 32'd1;
		if (event_total != 0 && ring_mask[prev[HIST_AW-1:0]] == m)
			return;
		ring_time[event_total[HIST_AW-1:0]] = t;
		ring_mask[event_total[HIST_AW-1:0]] = m;
		event_total = event_total + 32'd1;
	endtask

	task automatic change_mask(input chmask_t m, input logic [31:0] t, output bit changed);
		chmask_t rise;
		changed = 1'b0;
		if (m != mask_q) begin
			rise = m & ~mask_q;
			for (int i = 0; i < CHANNELS; i++)
				if (rise[i])
					on_time_q[i] = t;
			mask_q = m;
			log_event(m, t);
			changed = 1'b1;
		end
	endtask

	task automatic predict_command(input cmd_item_t it);
		log_word_t   w;
		bit          changed;
		bit          idx_ok;
		chmask_t     bit_m;
		logic [31:0] cap, span, lo, start, avail, slot;
		w = '{default: '0};
		w.is_last = 1'b1;
		changed = 1'b0;
		idx_ok = it.idx >= 1 && it.idx <= CHANNELS;
		case (it.cmd)
			CMD_SET: begin
				if (idx_ok) begin
					bit_m = chmask_t'(1) << (it.idx - 1);
					change_mask(it.on ? (mask_q | bit_m) : (mask_q & ~bit_m), it.now, changed);
				end
			end
			CMD_CLEAR: change_mask('0, it.now, changed);
			CMD_LOAD: change_mask(it.run ? it.nm[CHANNELS-1:0] : '0, it.now, changed);
			CMD_QUERY: begin
				if (idx_ok) begin
					w.chan_on = mask_q[it.idx - 1];
					w.on_ms   = on_time_q[it.idx - 1];
				end
			end
			CMD_READ: begin
				w.mask_now = mask_q;
				if (it.maxe == 0) begin
					w.next_seq = it.from;
					expected_words.push_back(w);
				end else if (event_total == 0) begin
					expected_words.push_back(w);
				end else begin
					cap   = (it.maxe > MAX_RESULTS) ? MAX_RESULTS : it.maxe;
					span  = (event_total > HISTORY_DEPTH) ? HISTORY_DEPTH : event_total;
					lo    = event_total - span;
					start = (it.from < lo) ? lo : it.from;
					if (start > event_total)
						start = event_total;
					avail = event_total - start;
					if (avail > cap)
						avail = cap;
					if (avail == 0) begin
						w.next_seq = start;
						expected_words.push_back(w);
					end else begin
						for (int k = 0; k < avail; k++) begin
							slot = start + k;
							w.entry_valid = 1'b1;
							w.entry_time  = ring_time[slot[HIST_AW-1:0]];
							w.entry_mask  = ring_mask[slot[HIST_AW-1:0]];
							w.next_seq    = start + avail;
							w.is_last     = (k + 1 == avail);
							expected_words.push_back(w);
						end
					end
				end
			end
			default: ;
		endcase
		if (it.cmd != CMD_READ) begin
			w.mask_now = mask_q;
			w.changed  = changed;
			expected_words.push_back(w);
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	task automatic queue_command(input cmd_t cmd, input logic [3:0] idx, input logic on,
			input logic [15:0] nm, input logic run, input logic [31:0] now,
			input logic [31:0] from, input logic [4:0] maxe, input bit drain);
		cmd_item_t it;
		it = '{cmd, idx, on, nm, run, now, from, maxe, drain};
		pending_cmds.push_back(it);
	endtask

	// driver: bursts of words with random gaps
	int burst_left;
	int gap_left;
	bit take_next;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= CMD_SET;
			burst_left = 1;
			gap_left = 0;
		end else begin
			take_next = !s_tvalid;
			if (s_tvalid && s_tready) begin
				predict_command(pending_cmds[0]);
				pending_cmds.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
				take_next = 1'b1;
			end
			if (take_next) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_cmds.size() != 0 &&
						!(pending_cmds[0].drain && expected_words.size() != 0)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {5'd0, pending_cmds[0].maxe, pending_cmds[0].from,
						pending_cmds[0].now, pending_cmds[0].run, pending_cmds[0].nm,
						pending_cmds[0].on, pending_cmds[0].idx};
					s_tuser  <= pending_cmds[0].cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: rotating stall pattern, reloaded when pat_age wraps, sometimes no stall at all
	logic [15:0] ready_pat;
	int          pat_age;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_pat = 16'hFFFF;
			pat_age = 0;
		end else begin
			if (pat_age == 31) begin
				pat_age = 0;
				case ($urandom_range(0, 3))
					0: ready_pat = 16'hFFFF;
					1: ready_pat = 16'($urandom);
					2: ready_pat = 16'($urandom | $urandom);
					default: ready_pat = 16'($urandom & $urandom);
				endcase
				if (ready_pat == 0)
					ready_pat = 16'h0001;
			end else begin
				pat_age++;
			end
			ready_pat = {ready_pat[0], ready_pat[15:1]};
			m_tready <= ready_pat[0];
		end
	end

	// monitor
	log_word_t got;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected: tdata 0x%0h", m_tdata);
				errors++;
			end else begin
				got = expected_words.pop_front();
				check_field("mask_now", 32'(got.mask_now), 32'(m_tdata[9:0]));
				check_field("mask_changed", 32'(got.changed), 32'(m_tdata[10]));
				check_field("channel_on", 32'(got.chan_on), 32'(m_tdata[11]));
				check_field("channel_last_on_ms", got.on_ms, m_tdata[43:12]);
				check_field("entry_time_ms", got.entry_time, m_tdata[75:44]);
				check_field("entry_mask", 32'(got.entry_mask), 32'(m_tdata[85:76]));
				check_field("next_seq", got.next_seq, m_tdata[117:86]);
				check_field("entry_valid", 32'(got.entry_valid), 32'(m_tuser));
				check_field("last", 32'(got.is_last), 32'(m_tlast));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		cmd_t       cmd;
		logic [4:0] maxe;
		logic [31:0] from;

		mask_q = '0;
		event_total = '0;
		for (int i = 0; i < CHANNELS; i++)
			on_time_q[i] = '0;
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			ring_time[i] = '0;
			ring_mask[i] = '0;
		end

		// directed opening
		queue_command(CMD_READ,  0, 0, 0, 1, 32'd5, 32'd0, 5'd4, 0);	// empty history
		queue_command(CMD_READ,  0, 0, 0, 1, 32'd6, 32'hFFFF_FFFF, 5'd0, 0);	// echo
		queue_command(CMD_QUERY, 0, 0, 0, 1, 32'd7, 0, 0, 0);
		queue_command(CMD_QUERY, 15, 1, 16'hFFFF, 1, 32'd8, 0, 0, 0);
		queue_command(CMD_SET,   1, 1, 0, 1, 32'd100, 0, 0, 0);
		queue_command(CMD_SET,   10, 1, 0, 1, 32'hFFFF_FFFF, 0, 0, 0);
		queue_command(CMD_SET,   0, 1, 0, 1, 32'd101, 0, 0, 0);
		queue_command(CMD_SET,   11, 1, 0, 1, 32'd102, 0, 0, 0);
		queue_command(CMD_SET,   1, 1, 0, 1, 32'd103, 0, 0, 0);	// already on
		queue_command(CMD_QUERY, 1, 0, 0, 0, 32'd104, 0, 0, 0);
		queue_command(CMD_QUERY, 10, 0, 0, 0, 32'd105, 0, 0, 0);
		queue_command(CMD_LOAD,  0, 0, 16'hFFFF, 1, 32'd200, 0, 0, 0);	// trimmed
		queue_command(CMD_LOAD,  0, 0, 16'h5555, 0, 32'd300, 0, 0, 0);	// not running
		queue_command(CMD_CLEAR, 0, 0, 0, 1, 32'd310, 0, 0, 0);	// already empty
		queue_command(CMD_LOAD,  0, 0, 16'h02AA, 1, 32'd320, 0, 0, 0);
		queue_command(CMD_SET,   3, 0, 0, 1, 32'd330, 0, 0, 0);
		queue_command(CMD_SET,   2, 0, 0, 1, 32'd335, 0, 0, 0);
		queue_command(CMD_CLEAR, 0, 0, 0, 1, 32'd340, 0, 0, 0);
		queue_command(CMD_SPARE_LO, 5, 1, 16'hFFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			5'd31, 0);
		queue_command(CMD_SPARE_HI, 1, 1, 16'h00FF, 1, 32'd350, 0, 0, 0);
		queue_command(CMD_READ,  0, 0, 0, 1, 32'd360, 32'd0, 5'd31, 1);	// oversized
		queue_command(CMD_READ,  0, 0, 0, 1, 32'd361, 32'hFFFF_FFFF, 5'd16, 0);
		queue_command(CMD_READ,  0, 0, 0, 1, 32'd362, 32'd2, 5'd2, 0);
		queue_command(CMD_QUERY, 11, 0, 0, 1, 32'd363, 0, 0, 0);
		queue_command(CMD_QUERY, 2, 0, 0, 1, 32'd364, 0, 0, 0);

		// random part, weighted towards mask changes and history reads
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6:  cmd = CMD_SET;
				7:                    cmd = CMD_CLEAR;
				8, 9, 10, 11:         cmd = CMD_LOAD;
				12, 13, 14:           cmd = CMD_QUERY;
				15, 16, 17, 18:       cmd = CMD_READ;
				default:              cmd = cmd_t'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
			endcase
			case ($urandom_range(0, 6))
				0:       maxe = 5'd0;
				1:       maxe = 5'($urandom_range(MAX_RESULTS + 1, 31));
				default: maxe = 5'($urandom_range(1, MAX_RESULTS));
			endcase
			case ($urandom_range(0, 4))
				0:       from = $urandom;
				1:       from = 32'd0;
				default: from = $urandom_range(0, 160);
			endcase
			queue_command(cmd,
				4'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) :
					$urandom_range(1, CHANNELS)),
				1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)),
				$urandom_range(0, 4) != 0, $urandom, from, maxe, n % 40 == 39);
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_cmds.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
